/* design/gtle_pkg.sv */
// ----------------------------------------------------------------------------
// gtle_pkg
// shared types and constants of the gbk text layout engine: payload words,
// register indexes, glyph kinds and controller states
// ----------------------------------------------------------------------------
`default_nettype none

package gtle_pkg;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] REG_FONT_SIZE     = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_SCREEN_WIDTH  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_SCREEN_HEIGHT = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_LARGE_BASE    = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_SMALL_BASE    = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_DRAW_MODE     = 3'd5;
  localparam int unsigned CfgDataW = 24;

  // reset values of the configuration registers
  localparam logic [4:0]  FONT_SIZE_RST     = 5'd16;
  localparam logic [7:0]  SCREEN_WIDTH_RST  = 8'd240;
  localparam logic [7:0]  SCREEN_HEIGHT_RST = 8'd240;

  // glyph kinds
  localparam logic [1:0] KIND_ASCII = 2'd0;
  localparam logic [1:0] KIND_GBK   = 2'd1;
  localparam logic [1:0] KIND_BLANK = 2'd2;

  // character codes and gbk table constants
  localparam logic [7:0] CHAR_NUL     = 8'h00;
  localparam logic [7:0] CHAR_CR      = 8'd13;
  localparam logic [7:0] ASCII_MAX    = 8'h80;
  localparam logic [7:0] LEAD_MIN     = 8'h81;
  localparam logic [7:0] TRAIL_MIN    = 8'h40;
  localparam logic [7:0] TRAIL_GAP    = 8'h7f;
  localparam logic [7:0] TRAIL_HI_OFS = 8'h41;
  localparam logic [7:0] CODE_BAD     = 8'hff;
  localparam logic [7:0] ROW_CODES    = 8'd190;
  localparam logic [4:0] LARGE_SIZE   = 5'd16;
  localparam logic [7:0] LARGE_PIX    = 8'd16;
  localparam logic [7:0] SMALL_PIX    = 8'd12;
  localparam logic [5:0] LARGE_BYTES  = 6'd32;
  localparam logic [5:0] SMALL_BYTES  = 6'd24;

  // glyph index within a table: 190 * 125 + 189 fits in 15 bits
  localparam int unsigned GlyphIdxW = 15;

  typedef struct packed {
    logic       begins_string;
    logic [7:0] start_x;
    logic [7:0] start_y;
    logic [7:0] char_byte;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  glyph_kind;
    logic [7:0]  pos_x;
    logic [7:0]  pos_y;
    logic [7:0]  ascii_code;
    logic [23:0] font_address;
    logic [5:0]  glyph_bytes;
  } out_word_t;

  typedef enum logic {
    ST_IDLE,
    ST_CALC
  } ctrl_state_e;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic load_out;
  } gtle_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic has_result;
    logic out_free;
  } gtle_sts_t;

endpackage

`default_nettype wire

/* design/gbk_text_layout_engine.sv */
// ----------------------------------------------------------------------------
// gbk_text_layout_engine
// turns a mixed ascii / gbk byte string into glyph draw words with cursor
// placement and gbk font flash addresses
//
//   channel   direction  handshake                  word
//   in        input      in_valid_i / in_stall_o    gtle_pkg::in_word_t
//   out       output     out_valid_o / out_stall_i  gtle_pkg::out_word_t
//   cfg       input      cfg_we_i                   cfg_index_i, cfg_data_i
//
// a byte without a draw word leaves the controller idle; a byte with a draw word
// moves it to the address stage for the font address multiply and add, and
// stays there while the word before it still waits on out_stall_i
// the output register frees the input side: a new byte is taken while a
// finished word still waits on out_stall_i
// reset leaves the string stopped until a word with begins_string arrives
// ----------------------------------------------------------------------------
`default_nettype none

module gbk_text_layout_engine (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           cfg_we_i,
  input  wire  [gtle_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire  [gtle_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire                           in_valid_i,
  output logic                          in_stall_o,
  input  gtle_pkg::in_word_t            in_data_i,
  output logic                          out_valid_o,
  input  wire                           out_stall_i,
  output gtle_pkg::out_word_t           out_data_o
);
  import gtle_pkg::*;

  gtle_cmd_t cmd;
  gtle_sts_t sts;

  // controller
  gtle_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .sts_i      (sts),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  // datapath
  gtle_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .out_stall_i (out_stall_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

/* design/gtle_ctrl.sv */
// ----------------------------------------------------------------------------
// gtle_ctrl
// controller: takes a byte, waits for the address stage and hands the word
// to the output register
// ----------------------------------------------------------------------------
`default_nettype none

module gtle_ctrl (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  input  gtle_pkg::gtle_sts_t sts_i,
  output logic               in_stall_o,
  output gtle_pkg::gtle_cmd_t cmd_o
);
  import gtle_pkg::*;

  ctrl_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && sts_i.has_result) state_d = ST_CALC;
      end
      ST_CALC: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall_o     = 1'b1;
    cmd_o.accept   = 1'b0;
    cmd_o.load_out = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.accept = in_valid_i;
      end
      ST_CALC: begin
        cmd_o.load_out = sts_i.out_free;
      end
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  a_calc_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CALC && !sts_i.out_free) |=> state_q == ST_CALC)
    else $error("controller left the address stage without a free output");
  a_no_result_stays_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && in_valid_i && !sts_i.has_result) |=> state_q == ST_IDLE)
    else $error("controller busy after a word without result");
  a_load_only_in_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> (state_q == ST_CALC && in_stall_o))
    else $error("output load outside the address stage");
`endif

endmodule

`default_nettype wire

/* design/gtle_dp.sv */
// ----------------------------------------------------------------------------
// gtle_dp
// datapath: configuration registers, text cursor state, gbk index stage,
// font address multiply and output register
// ----------------------------------------------------------------------------
`default_nettype none

module gtle_dp (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_we_i,
  input  wire  [gtle_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  wire  [gtle_pkg::CfgDataW-1:0]    cfg_data_i,
  input  gtle_pkg::in_word_t               in_data_i,
  input  wire                              out_stall_i,
  input  gtle_pkg::gtle_cmd_t              cmd_i,
  output gtle_pkg::gtle_sts_t              sts_o,
  output logic                             out_valid_o,
  output gtle_pkg::out_word_t              out_data_o
);
  import gtle_pkg::*;

  // configuration registers
  logic [4:0]  font_size_q;
  logic [7:0]  screen_width_q, screen_height_q;
  logic [23:0] large_base_q, small_base_q;

  // cursor state
  logic [7:0] cursor_x_q, cursor_x_d, cursor_y_q, cursor_y_d;
  logic [7:0] lead_byte_q, lead_byte_d;
  logic       lead_pending_q, lead_pending_d;
  logic       skip_next_q, skip_next_d;
  logic       stopped_q, stopped_d;

  // address stage
  logic [1:0]           st_kind_q, st_kind_d;
  logic [7:0]           st_x_q, st_x_d, st_y_q, st_y_d, st_code_q, st_code_d;
  logic [GlyphIdxW-1:0] st_idx_q, st_idx_d;
  logic [5:0]           st_bytes_q;
  logic [23:0]          st_base_q;

  // output register
  logic      out_valid_q, out_valid_d;
  out_word_t out_q, out_d;

  // per byte working values
  logic [7:0] size_pix, half_pix, wrap_w, cx0, cy0, cxw, cyw, trail_ofs;
  logic       lp0, sk0, st0, wrap_hit, stop_hit, bad_code, has_res;
  logic [5:0] nbytes;
  logic [23:0] base_sel;
  logic [GlyphIdxW-1:0] row_part;
  logic [20:0] prod;

  // configuration writes; draw mode only matters downstream and is not kept
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      font_size_q     <= FONT_SIZE_RST;
      screen_width_q  <= SCREEN_WIDTH_RST;
      screen_height_q <= SCREEN_HEIGHT_RST;
      large_base_q    <= '0;
      small_base_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_FONT_SIZE:     font_size_q     <= cfg_data_i[4:0];
        REG_SCREEN_WIDTH:  screen_width_q  <= cfg_data_i[7:0];
        REG_SCREEN_HEIGHT: screen_height_q <= cfg_data_i[7:0];
        REG_LARGE_BASE:    large_base_q    <= cfg_data_i;
        REG_SMALL_BASE:    small_base_q    <= cfg_data_i;
        REG_DRAW_MODE:     ;
        default:           ;
      endcase
    end
  end

  // font size selection
  assign size_pix = (font_size_q == LARGE_SIZE) ? LARGE_PIX : SMALL_PIX;
  assign half_pix = size_pix >> 1;
  assign nbytes   = (font_size_q == LARGE_SIZE) ? LARGE_BYTES : SMALL_BYTES;
  assign base_sel = (font_size_q == LARGE_SIZE) ? large_base_q : small_base_q;

  // start of string overrides the cursor and flags
  assign cx0 = in_data_i.begins_string ? in_data_i.start_x : cursor_x_q;
  assign cy0 = in_data_i.begins_string ? in_data_i.start_y : cursor_y_q;
  assign lp0 = in_data_i.begins_string ? 1'b0 : lead_pending_q;
  assign sk0 = in_data_i.begins_string ? 1'b0 : skip_next_q;
  assign st0 = in_data_i.begins_string ? 1'b0 : stopped_q;

  // line wrap and screen bottom tests, done on 9 bits without sign
  assign wrap_w   = lp0 ? size_pix : half_pix;
  assign wrap_hit = ({1'b0, cx0} + {1'b0, wrap_w}) > {1'b0, screen_width_q};
  assign cxw      = wrap_hit ? 8'd0 : cx0;
  assign cyw      = wrap_hit ? cy0 + size_pix : cy0;
  assign stop_hit = ({1'b0, cyw} + {1'b0, size_pix}) > {1'b0, screen_height_q};

  // gbk code check and glyph index
  assign bad_code = (lead_byte_q < LEAD_MIN) || (lead_byte_q == CODE_BAD) ||
                    (in_data_i.char_byte < TRAIL_MIN) ||
                    (in_data_i.char_byte == TRAIL_GAP) ||
                    (in_data_i.char_byte == CODE_BAD);
  assign trail_ofs = (in_data_i.char_byte < TRAIL_GAP) ?
                     in_data_i.char_byte - TRAIL_MIN :
                     in_data_i.char_byte - TRAIL_HI_OFS;
  assign row_part  = GlyphIdxW'(lead_byte_q - LEAD_MIN) * GlyphIdxW'(ROW_CODES);

  // byte decode and cursor update
  always_comb begin
    cursor_x_d     = cx0;
    cursor_y_d     = cy0;
    lead_byte_d    = lead_byte_q;
    lead_pending_d = lp0;
    skip_next_d    = sk0;
    stopped_d      = st0;
    has_res        = 1'b0;
    st_kind_d      = KIND_ASCII;
    st_x_d         = cxw;
    st_y_d         = cyw;
    st_code_d      = in_data_i.char_byte;
    st_idx_d       = row_part + GlyphIdxW'(trail_ofs);
    if (!st0) begin
      if (in_data_i.char_byte == CHAR_NUL) begin
        stopped_d      = 1'b1;
        lead_pending_d = 1'b0;
        skip_next_d    = 1'b0;
      end else if (sk0) begin
        skip_next_d = 1'b0;
      end else if (lp0) begin
        // trail byte of a gbk pair
        lead_pending_d = 1'b0;
        cursor_x_d     = cxw;
        cursor_y_d     = cyw;
        if (stop_hit) begin
          stopped_d   = 1'b1;
          skip_next_d = 1'b0;
        end else begin
          has_res    = 1'b1;
          st_kind_d  = bad_code ? KIND_BLANK : KIND_GBK;
          st_code_d  = 8'd0;
          cursor_x_d = cxw + size_pix;
        end
      end else if (in_data_i.char_byte > ASCII_MAX) begin
        lead_byte_d    = in_data_i.char_byte;
        lead_pending_d = 1'b1;
      end else begin
        cursor_x_d = cxw;
        cursor_y_d = cyw;
        if (stop_hit) begin
          stopped_d = 1'b1;
        end else if (in_data_i.char_byte == CHAR_CR) begin
          // new line, the byte after it is dropped
          cursor_y_d  = cyw + size_pix;
          cursor_x_d  = 8'd0;
          skip_next_d = 1'b1;
        end else begin
          has_res    = 1'b1;
          cursor_x_d = cxw + half_pix;
        end
      end
    end
  end

  // cursor state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_x_q     <= '0;
      cursor_y_q     <= '0;
      lead_byte_q    <= '0;
      lead_pending_q <= 1'b0;
      skip_next_q    <= 1'b0;
      stopped_q      <= 1'b1;
    end else if (cmd_i.accept) begin
      cursor_x_q     <= cursor_x_d;
      cursor_y_q     <= cursor_y_d;
      lead_byte_q    <= lead_byte_d;
      lead_pending_q <= lead_pending_d;
      skip_next_q    <= skip_next_d;
      stopped_q      <= stopped_d;
    end
  end

  // address stage registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      st_kind_q  <= st_kind_d;
      st_x_q     <= st_x_d;
      st_y_q     <= st_y_d;
      st_code_q  <= st_code_d;
      st_idx_q   <= st_idx_d;
      st_bytes_q <= nbytes;
      st_base_q  <= base_sel;
    end
  end

  // font address of a gbk glyph: index times bitmap length plus table base; zero for other kinds
  assign prod = 21'(st_idx_q) * 21'(st_bytes_q);

  always_comb begin
    out_d.glyph_kind   = st_kind_q;
    out_d.pos_x        = st_x_q;
    out_d.pos_y        = st_y_q;
    out_d.ascii_code   = st_code_q;
    out_d.font_address = (st_kind_q == KIND_GBK) ? st_base_q + 24'(prod) : 24'd0;
    out_d.glyph_bytes  = st_bytes_q;
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q <= out_d;
    end
  end

  assign sts_o.has_result = has_res;
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;
  assign out_valid_o      = out_valid_q;
  assign out_data_o       = out_q;

`ifndef ASSERT_OFF
  a_stopped_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stopped_q |-> (!lead_pending_q && !skip_next_q))
    else $error("stopped string still holds a lead or skip flag");
  a_lead_skip_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(lead_pending_q && skip_next_q))
    else $error("lead byte pending while skipping");
  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |=> out_valid_q)
    else $error("output load lost");
  a_no_load_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !cmd_i.load_out)
    else $error("output overwritten while stalled");
`endif

endmodule

`default_nettype wire
